>>> sv/hsi_pkg.sv
// Package for the hash set block: sizes, beat types and the bucket row layout.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package hsi_pkg;

  // The bucket count must stay a power of two so that the bucket index is
  // simply the low bits of the key.
  localparam int NUM_BUCKETS = 16384;
  localparam int WAYS        = 4;
  localparam int KEY_W       = 31;
  localparam int BKT_W       = $clog2(NUM_BUCKETS);
  localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int FILL_W      = $clog2(WAYS + 1);

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic found;
    logic bucket_full;
  } res_item_t;

  // One memory row holds a whole bucket: its fill count and all of its slots.
  typedef struct packed {
    logic [FILL_W-1:0]           fill;
    logic [WAYS-1:0][KEY_W-1:0] keys;
  } bucket_row_t;

  typedef struct packed {
    logic done;
    logic hit;
  } scan_stat_t;

  function automatic logic [BKT_W-1:0] bucket_of(input logic [KEY_W-1:0] key);
    return key[BKT_W-1:0];
  endfunction

endpackage

>>> sv/hash_set_insert_lookup.sv
// Top level of the hash set: handshakes, sequencer, clearing pass, result register.
// Depends on hsi_pkg, hsi_bucket_mem and hsi_scan.
`timescale 1ns / 1ps

// Channel   Direction  Handshake         Beat
// in_       input      in_valid/in_stall  in_item_t  (req_type, key)
// out_      output     out_valid/out_stall res_item_t (found, bucket_full)
//
// After reset the block sweeps every bucket row to empty, one row a cycle,
// with in_stall high throughout. An insert then reads the bucket row, decides
// and writes it back, then registers its result beat. A query reads and decides
// in the same way, then compares the filled slots one at a time, up to WAYS,
// stopping at the first match; a query on an empty bucket skips the compares.
// Only one request is in flight, and the input reopens together with the
// registering of the result. A stalled result waits in the output register, so
// one more request is let in; its result then holds in_stall high until it
// moves on.

module hash_set_insert_lookup
  import hsi_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output res_item_t out_data
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_SCAN,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [BKT_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  in_item_t          req_r, req_nxt;
  res_item_t         res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_item_t         out_data_r, out_data_nxt;

  logic              in_accept;
  logic              mem_wr_en;
  logic [BKT_W-1:0]  mem_wr_addr;
  bucket_row_t       mem_wr_data;
  bucket_row_t       mem_rd_data;
  bucket_row_t       row_upd;
  logic              scan_start;
  scan_stat_t        scan_stat;
  logic              out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  hsi_bucket_mem u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (in_accept),
    .rd_addr (bucket_of(in_data.key)),
    .rd_data (mem_rd_data)
  );

  hsi_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (scan_start),
    .key   (req_r.key),
    .row   (mem_rd_data),
    .stat  (scan_stat)
  );

  // The row as written back by an insert: the key goes into the first free
  // slot and the fill count moves up by one.
  always_comb begin
    row_upd = mem_rd_data;
    row_upd.keys[mem_rd_data.fill[WAY_W-1:0]] = req_r.key;
    row_upd.fill = mem_rd_data.fill + FILL_W'(1);
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = clr_cnt_r;
    mem_wr_data   = '0;
    scan_start    = 1'b0;

    // The downstream side takes the waiting result.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        // Empty rows: zero fill count, and zero keys for tidiness.
        mem_wr_en   = 1'b1;
        clr_cnt_nxt = clr_cnt_r + BKT_W'(1);
        if (clr_cnt_r == BKT_W'(NUM_BUCKETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          req_nxt   = in_data;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        res_nxt = '0;
        if (req_r.req_type == REQ_INSERT) begin
          if (mem_rd_data.fill >= FILL_W'(WAYS)) begin
            res_nxt.bucket_full = 1'b1;
          end else begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = bucket_of(req_r.key);
            mem_wr_data = row_upd;
          end
          state_nxt = S_DONE;
        end else if (mem_rd_data.fill == '0) begin
          state_nxt = S_DONE;
        end else begin
          scan_start = 1'b1;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_stat.done) begin
          res_nxt.found = scan_stat.hit;
          state_nxt     = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  // Only one request is in flight: acceptance closes the input at once.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> in_stall)
    else $error("input accepted while a request was still in flight");

  // A result never flags both a hit and a dropped insert.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.found && out_data.bucket_full))
    else $error("result flags both found and bucket_full");

  // The memory is written only by the clearing pass or by an insert.
  assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |-> (state_r == S_CLEAR) ||
                  ((state_r == S_EVAL) && (req_r.req_type == REQ_INSERT)))
    else $error("bucket memory written outside clearing or insert");

  // The scanner finishes only while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (!rst_n)
    scan_stat.done |-> (state_r == S_SCAN))
    else $error("scan finished outside the scan state");
`endif

endmodule

>>> sv/hsi_bucket_mem.sv
// Bucket memory: one row per bucket, one write and one registered read a cycle.
// Depends on hsi_pkg for the row type and the bucket count.
`timescale 1ns / 1ps

module hsi_bucket_mem
  import hsi_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [BKT_W-1:0]  wr_addr,
  input  bucket_row_t       wr_data,
  input  logic              rd_en,
  input  logic [BKT_W-1:0]  rd_addr,
  output bucket_row_t       rd_data
);

  bucket_row_t mem [NUM_BUCKETS];
  bucket_row_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // The read word holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/hsi_scan.sv
// Slot scanner: one shared key comparator stepped over the filled slots of a row.
// Depends on hsi_pkg for the row type and the status struct.
`timescale 1ns / 1ps

module hsi_scan
  import hsi_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [KEY_W-1:0]  key,
  input  bucket_row_t       row,
  output scan_stat_t        stat
);

  logic             busy_r, busy_nxt;
  logic [WAY_W-1:0] way_r, way_nxt;
  logic             match;
  logic             last;

  // The single comparator of the block.
  assign match = (row.keys[way_r] == key);
  assign last  = ((FILL_W'(way_r) + FILL_W'(1)) == row.fill);

  always_comb begin
    busy_nxt  = busy_r;
    way_nxt   = way_r;
    stat.done = 1'b0;
    stat.hit  = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      way_nxt  = '0;
    end else if (busy_r) begin
      if (match || last) begin
        stat.done = 1'b1;
        stat.hit  = match;
        busy_nxt  = 1'b0;
      end else begin
        way_nxt = way_r + WAY_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      way_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      way_r  <= way_nxt;
    end
  end

endmodule

>>> tb/sv/hsi_shadow_pkg.sv
// Shadow copy of the hash set contents and the queue of answers still owed by the block.
// Depends on hsi_pkg for the sizes, the request codes and the beat types.
`timescale 1ns / 1ps

package hsi_shadow_pkg;

  import hsi_pkg::*;

  typedef struct {
    in_item_t  req;
    res_item_t answer;
  } pending_answer_t;

  class hash_set_shadow;

    logic [KEY_W-1:0] stored_keys [NUM_BUCKETS][WAYS];
    int unsigned      fill_count [NUM_BUCKETS];
    pending_answer_t  answers_due [$];
    int unsigned      error_count;
    int unsigned      answers_checked;

    function new();
      error_count     = 0;
      answers_checked = 0;
      foreach (fill_count[b]) fill_count[b] = 0;
    endfunction

    // Only the first ten problems are printed; the rest are only counted.
    function void flag(string what);
      error_count++;
      if (error_count <= 10) $display("%s", what);
    endfunction

    // Applies one accepted request to the shadow set and queues the answer it must produce.
    function void take_request(in_item_t req);
      pending_answer_t due;
      int unsigned     b;
      int unsigned     w;
      due.req    = req;
      due.answer = '0;
      b = req.key % NUM_BUCKETS;
      if (req.req_type == REQ_QUERY) begin
        // Only filled slots take part, so unwritten slots are never looked at.
        for (w = 0; w < fill_count[b]; w++) begin
          if (stored_keys[b][w] == req.key) due.answer.found = 1'b1;
        end
      end else if (fill_count[b] >= WAYS) begin
        due.answer.bucket_full = 1'b1;
      end else begin
        stored_keys[b][fill_count[b]] = req.key;
        fill_count[b]++;
      end
      answers_due.push_back(due);
    endfunction

    function void check_answer(res_item_t got);
      pending_answer_t due;
      if (answers_due.size() == 0) begin
        flag($sformatf("Unexpected result beat: found=%0b bucket_full=%0b",
                       got.found, got.bucket_full));
        return;
      end
      due = answers_due.pop_front();
      if (got.found !== due.answer.found || got.bucket_full !== due.answer.bucket_full) begin
        flag($sformatf({"Result %0d for %s key 0x%08h: expected found=%0b bucket_full=%0b,",
                        " got found=%0b bucket_full=%0b"},
                       answers_checked, (due.req.req_type == REQ_QUERY) ? "query" : "insert",
                       due.req.key, due.answer.found, due.answer.bucket_full,
                       got.found, got.bucket_full));
      end
      answers_checked++;
    endfunction

    function int unsigned answers_pending();
      return answers_due.size();
    endfunction

    function void close_out();
      if (answers_due.size() != 0)
        flag($sformatf("%0d expected results never arrived", answers_due.size()));
    endfunction

  endclass

endpackage

>>> tb/sv/hash_set_insert_lookup_tb.sv
// Self-checking bench for the hash set block: directed and random insert/query beats,
// checked against a shadow copy of the set. Depends on hsi_pkg, hsi_shadow_pkg and the block.
`timescale 1ns / 1ps

module hash_set_insert_lookup_tb;

  import hsi_pkg::*;
  import hsi_shadow_pkg::*;

  // Number of random requests after the directed opening.
  localparam int RANDOM_ITEMS = 1700;
  // Size of the pool of buckets that most random traffic is aimed at. With 16384
  // buckets, purely random keys would almost never share a bucket, so nothing
  // would ever fill up or need more than one slot compared.
  localparam int HOT_N = 64;
  // The receiver holds off for a long stretch after this many beats, twice over.
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 300;
  // After the last answer, a margin beyond the slowest query is allowed for any
  // stray beat to show up.
  localparam int DRAIN_CYCLES = 24;
  // The slowest correct run is the clearing pass plus the traffic under the
  // heaviest stalls; this allows well beyond that.
  localparam int TIMEOUT_NS = 8_000_000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  res_item_t out_data;

  hash_set_shadow shadow;

  // Sender burst state: how many more beats to offer back to back before the next gap.
  int unsigned burst_left = 0;

  // Buckets that random traffic concentrates on, and keys inserted recently.
  logic [BKT_W-1:0] hot_buckets [HOT_N];
  logic [KEY_W-1:0] known_keys [$];

  hash_set_insert_lookup dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Reset is asserted from the start and released once; the block then runs its
  // clearing pass with in_stall high, which the sender simply waits out.
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // A hung block or a lost beat ends the run here.
  initial begin
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic in_item_t req_of(logic kind, logic [KEY_W-1:0] key);
    in_item_t r;
    r.req_type = kind;
    r.key      = key;
    return r;
  endfunction

  // Picks one random request. Most of them are aimed at the hot buckets or at keys
  // already inserted, so that buckets fill up, duplicates pile up and queries hit in
  // every slot position; a small share is unrestricted noise.
  function automatic in_item_t random_request();
    in_item_t         r;
    int unsigned      pick;
    logic [BKT_W-1:0] bkt;
    pick       = $urandom_range(0, 99);
    bkt        = hot_buckets[$urandom_range(0, HOT_N - 1)];
    r.req_type = REQ_QUERY;
    r.key      = KEY_W'($urandom);
    if (pick < 8) begin
      r.req_type = 1'($urandom_range(0, 1));
    end else if (pick < 50) begin
      r.req_type          = REQ_INSERT;
      r.key[BKT_W-1:0]    = bkt;
    end else if (pick < 58) begin
      // A key inserted before goes in again and, if its bucket has room, takes up another slot.
      r.req_type = REQ_INSERT;
      if (known_keys.size() != 0) r.key = known_keys[$urandom_range(0, known_keys.size() - 1)];
    end else if (pick < 82) begin
      if (known_keys.size() != 0) r.key = known_keys[$urandom_range(0, known_keys.size() - 1)];
    end else if (pick < 92) begin
      // Near miss: same bucket as a stored key, one upper bit different.
      if (known_keys.size() != 0) r.key = known_keys[$urandom_range(0, known_keys.size() - 1)];
      r.key = r.key ^ (KEY_W'(1) << $urandom_range(BKT_W, KEY_W - 1));
    end else begin
      r.key[BKT_W-1:0] = bkt;
    end
    return r;
  endfunction

  // Offers one request beat and returns at the edge where it is taken. The sender
  // works in bursts of random length; between bursts it drops valid for a random
  // gap, so gaps land on every phase of the block's work. A stalled beat is held
  // unchanged, and valid never looks at the stall.
  task automatic offer_request(input in_item_t req);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    shadow.take_request(req);
  endtask

  // Result side: takes each beat that goes through the handshake and checks it,
  // then chooses the stall for the next cycle. The stall rate changes in phases of
  // random length, from none at all to very heavy, and twice the receiver holds off
  // for a long stretch so that the output register fills and the input stalls.
  initial begin : result_sink
    int unsigned beats_taken;
    int unsigned hold_left;
    int unsigned holds_done;
    int unsigned stall_pct;
    int unsigned phase_left;
    beats_taken = 0;
    hold_left   = 0;
    holds_done  = 0;
    stall_pct   = 0;
    phase_left  = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        shadow.check_answer(out_data);
        beats_taken++;
      end
      if (hold_left == 0 && holds_done < 2 && beats_taken >= HOLD_AT * (holds_done + 1)) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (phase_left == 0) begin
        phase_left = $urandom_range(8, 160);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 30;
          2:       stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      phase_left--;
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  initial begin : stimulus
    in_item_t directed_q [$];
    in_item_t req;
    shadow = new();

    foreach (hot_buckets[i]) hot_buckets[i] = BKT_W'($urandom);
    // The lowest and the highest bucket are always among the hot ones.
    hot_buckets[0] = '0;
    hot_buckets[1] = BKT_W'(NUM_BUCKETS - 1);

    // Directed opening. A query on an empty bucket, then the smallest and largest keys.
    directed_q.push_back(req_of(REQ_QUERY,  KEY_W'(0)));
    directed_q.push_back(req_of(REQ_INSERT, KEY_W'(0)));
    directed_q.push_back(req_of(REQ_QUERY,  KEY_W'(0)));
    directed_q.push_back(req_of(REQ_QUERY,  KEY_W'(31'h7FFF_FFFF)));
    directed_q.push_back(req_of(REQ_INSERT, KEY_W'(31'h7FFF_FFFF)));
    directed_q.push_back(req_of(REQ_QUERY,  KEY_W'(31'h7FFF_FFFF)));
    // Same bucket as key zero but every upper bit set: must miss.
    directed_q.push_back(req_of(REQ_QUERY,  KEY_W'(31'h7FFF_C000)));
    // The same key four times fills its bucket; duplicates use up capacity.
    repeat (4) directed_q.push_back(req_of(REQ_INSERT, KEY_W'(5)));
    // The bucket is full: both a duplicate and a new key are dropped and flagged.
    directed_q.push_back(req_of(REQ_INSERT, KEY_W'(5)));
    directed_q.push_back(req_of(REQ_INSERT, KEY_W'(5 + NUM_BUCKETS)));
    directed_q.push_back(req_of(REQ_QUERY,  KEY_W'(5)));
    directed_q.push_back(req_of(REQ_QUERY,  KEY_W'(5 + NUM_BUCKETS)));
    // Alternating bit patterns, and a key that differs from one only in bit zero.
    directed_q.push_back(req_of(REQ_INSERT, KEY_W'(31'h2AAA_AAAA)));
    directed_q.push_back(req_of(REQ_INSERT, KEY_W'(31'h5555_5555)));
    directed_q.push_back(req_of(REQ_QUERY,  KEY_W'(31'h2AAA_AAAA)));
    directed_q.push_back(req_of(REQ_QUERY,  KEY_W'(31'h5555_5555)));
    directed_q.push_back(req_of(REQ_QUERY,  KEY_W'(31'h2AAA_AAAB)));
    // Fill the top bucket behind the largest key and hit in its last slot.
    directed_q.push_back(req_of(REQ_INSERT, KEY_W'(31'h0000_3FFF)));
    directed_q.push_back(req_of(REQ_INSERT, KEY_W'(31'h0000_7FFF)));
    directed_q.push_back(req_of(REQ_INSERT, KEY_W'(31'h0000_BFFF)));
    directed_q.push_back(req_of(REQ_QUERY,  KEY_W'(31'h0000_BFFF)));
    directed_q.push_back(req_of(REQ_QUERY,  KEY_W'(31'h0000_3FFF)));

    wait (rst_n == 1'b1);
    @(posedge clk);

    foreach (directed_q[i]) offer_request(directed_q[i]);

    repeat (RANDOM_ITEMS) begin
      // Now and then a hot bucket is swapped for a fresh one, so that buckets of
      // every fill level keep turning up rather than all of them ending full.
      if ($urandom_range(0, 99) < 6) hot_buckets[$urandom_range(2, HOT_N - 1)] = BKT_W'($urandom);
      req = random_request();
      if (req.req_type == REQ_INSERT) begin
        known_keys.push_back(req.key);
        if (known_keys.size() > 256) void'(known_keys.pop_front());
      end
      offer_request(req);
    end
    in_valid <= 1'b0;

    while (shadow.answers_pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    shadow.close_out();

    if (shadow.error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
